/* hw/rtl/ccc_pkg.sv */
// calendar clock package: widths, operation codes, item and time structs
// and the small calendar helpers (month length, leap test, year mod 25)
// no dependencies
package ccc_pkg;

    localparam int YEAR_BITS_DEF = 16;

    localparam int MS_W    = 10;
    localparam int SEC_W   = 6;
    localparam int MIN_W   = 6;
    localparam int HOUR_W  = 5;
    localparam int DAY_W   = 5;
    localparam int MONTH_W = 4;
    localparam int YEAR_W  = 16;
    localparam int FUNC_W  = 2;
    localparam int MOD25_W = 5;

    localparam logic [FUNC_W-1:0] FUNC_TICK    = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_ADD_SEC = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_LOAD    = 2'd2;

    localparam logic [MS_W-1:0]    TICK_LEN_RESET = 10'd10;
    localparam logic [MS_W-1:0]    MS_MAX         = 10'd999;
    localparam logic [SEC_W-1:0]   SEC_MAX        = 6'd59;
    localparam logic [MIN_W-1:0]   MIN_MAX        = 6'd59;
    localparam logic [HOUR_W-1:0]  HOUR_MAX       = 5'd23;
    localparam logic [MONTH_W-1:0] MONTH_MAX      = 4'd12;
    localparam logic [MONTH_W-1:0] MONTH_FIRST    = 4'd1;
    localparam logic [DAY_W-1:0]   DAY_FIRST      = 5'd1;
    localparam logic [MOD25_W-1:0] MOD25_MAX      = 5'd24;

    localparam int RESET_YEAR       = 2000;
    localparam int RESET_YEAR_MOD25 = RESET_YEAR % 25;

    typedef struct packed {
        logic [FUNC_W-1:0]  func;
        logic [MS_W-1:0]    load_ms;
        logic [SEC_W-1:0]   load_second;
        logic [MIN_W-1:0]   load_minute;
        logic [HOUR_W-1:0]  load_hour;
        logic [DAY_W-1:0]   load_day;
        logic [MONTH_W-1:0] load_month;
        logic [YEAR_W-1:0]  load_year;
    } item_t;

    typedef struct packed {
        logic [MS_W-1:0]    ms;
        logic [SEC_W-1:0]   second;
        logic [MIN_W-1:0]   minute;
        logic [HOUR_W-1:0]  hour;
        logic [DAY_W-1:0]   day;
        logic [MONTH_W-1:0] month;
        logic [YEAR_W-1:0]  year;
    } time_t;

    // leap when divisible by 4, except centuries not divisible by 400
    function automatic logic is_leap(input logic [3:0] low_bits,
                                     input logic [MOD25_W-1:0] rem25);
        return (low_bits[1:0] == 2'd0) && ((rem25 != '0) || (low_bits == 4'd0));
    endfunction

    function automatic logic [DAY_W-1:0] month_days(input logic [MONTH_W-1:0] m,
                                                    input logic leap);
        logic [DAY_W-1:0] d;
        case (m) inside
            4'd4, 4'd6, 4'd9, 4'd11: d = 5'd30;
            4'd2:                    d = leap ? 5'd29 : 5'd28;
            default:                 d = 5'd31;
        endcase
        return d;
    endfunction

    // residue folding: 16 = 16, 256 = 6, 4096 = 21, 32 = 7 (all mod 25)
    function automatic logic [MOD25_W-1:0] mod25(input logic [YEAR_W-1:0] v);
        logic [9:0] s;
        logic [7:0] t;
        logic [6:0] u;
        s = 10'(v[3:0]) + 10'(v[7:4]) * 10'd16 + 10'(v[11:8]) * 10'd6
            + 10'(v[15:12]) * 10'd21;
        t = 8'(s[4:0]) + 8'(s[9:5]) * 8'd7;
        u = 7'(t[4:0]) + 7'(t[7:5]) * 7'd7;
        if (u >= 7'd75)
            u = u - 7'd75;
        else if (u >= 7'd50)
            u = u - 7'd50;
        else if (u >= 7'd25)
            u = u - 7'd25;
        return u[MOD25_W-1:0];
    endfunction

endpackage

/* hw/rtl/ccc_if.sv */
// calendar clock channel interfaces: operation items in, time items out
// depends on ccc_pkg for field widths
interface ccc_op_if;
    logic                           valid;
    logic                           ready;
    logic [ccc_pkg::FUNC_W-1:0]     func;
    logic [ccc_pkg::MS_W-1:0]       load_ms;
    logic [ccc_pkg::SEC_W-1:0]      load_second;
    logic [ccc_pkg::MIN_W-1:0]      load_minute;
    logic [ccc_pkg::HOUR_W-1:0]     load_hour;
    logic [ccc_pkg::DAY_W-1:0]      load_day;
    logic [ccc_pkg::MONTH_W-1:0]    load_month;
    logic [ccc_pkg::YEAR_W-1:0]     load_year;

    modport source (
        output valid, func, load_ms, load_second, load_minute, load_hour,
               load_day, load_month, load_year,
        input  ready
    );
    modport sink (
        input  valid, func, load_ms, load_second, load_minute, load_hour,
               load_day, load_month, load_year,
        output ready
    );
endinterface

interface ccc_stamp_if;
    logic                           valid;
    logic                           ready;
    logic [ccc_pkg::MS_W-1:0]       cur_ms;
    logic [ccc_pkg::SEC_W-1:0]      cur_second;
    logic [ccc_pkg::MIN_W-1:0]      cur_minute;
    logic [ccc_pkg::HOUR_W-1:0]     cur_hour;
    logic [ccc_pkg::DAY_W-1:0]      cur_day;
    logic [ccc_pkg::MONTH_W-1:0]    cur_month;
    logic [ccc_pkg::YEAR_W-1:0]     cur_year;

    modport source (
        output valid, cur_ms, cur_second, cur_minute, cur_hour, cur_day,
               cur_month, cur_year,
        input  ready
    );
    modport sink (
        input  valid, cur_ms, cur_second, cur_minute, cur_hour, cur_day,
               cur_month, cur_year,
        output ready
    );
endinterface

/* hw/rtl/ccc_in_stage.sv */
// input register stage: one op item per cycle, unless the result stage stalls
// depends on ccc_pkg and ccc_if
module ccc_in_stage (
    input  logic           clk,
    input  logic           rst_n,
    ccc_op_if.sink         op,
    input  logic           advance,
    output logic           s1_valid,
    output ccc_pkg::item_t s1_item
);
    import ccc_pkg::*;

    logic  valid_reg;
    logic  valid_next;
    item_t item_reg;

    // the stage frees up whenever the result register moves on
    assign op.ready = !valid_reg || advance;

    always_comb
    begin
        valid_next = valid_reg;
        if (op.ready)
        begin
            valid_next = op.valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (op.valid && op.ready)
        begin
            item_reg <= '{func:        op.func,
                          load_ms:     op.load_ms,
                          load_second: op.load_second,
                          load_minute: op.load_minute,
                          load_hour:   op.load_hour,
                          load_day:    op.load_day,
                          load_month:  op.load_month,
                          load_year:   op.load_year};
        end
    end

    assign s1_valid = valid_reg;
    assign s1_item  = item_reg;
endmodule

/* hw/rtl/ccc_time_core.sv */
// time-of-day and date state with its next-state logic and carry chain
// depends on ccc_pkg
module ccc_time_core #(
    parameter int YEAR_BITS = ccc_pkg::YEAR_BITS_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       fire,
    input  ccc_pkg::item_t             item,
    input  logic [ccc_pkg::MS_W-1:0]   tick_len,
    output ccc_pkg::time_t             now_next
);
    import ccc_pkg::*;

    logic [MS_W-1:0]      ms_reg,    ms_next;
    logic [SEC_W-1:0]     sec_reg,   sec_next;
    logic [MIN_W-1:0]     min_reg,   min_next;
    logic [HOUR_W-1:0]    hour_reg,  hour_next;
    logic [DAY_W-1:0]     day_reg,   day_next;
    logic [MONTH_W-1:0]   mon_reg,   mon_next;
    logic [YEAR_BITS-1:0] year_reg,  year_next;
    // year mod 25 kept alongside the year for the century rule
    logic [MOD25_W-1:0]   ymod_reg,  ymod_next;

    logic [YEAR_BITS-1:0] ld_year;
    logic [YEAR_W-1:0]    ld_year16;
    logic [YEAR_W-1:0]    year16;
    logic [MOD25_W-1:0]   ld_mod25;
    logic                 ld_leap;
    logic                 cur_leap;
    logic [DAY_W-1:0]     cur_dim;

    for (genvar i = 0; i < YEAR_BITS; i++)
    begin : g_ld_year
        if (i < YEAR_W)
        begin : g_bit
            assign ld_year[i] = item.load_year[i];
        end
        else
        begin : g_zero
            assign ld_year[i] = 1'b0;
        end
    end

    for (genvar i = 0; i < YEAR_W; i++)
    begin : g_year16
        if (i < YEAR_BITS)
        begin : g_bit
            assign ld_year16[i] = item.load_year[i];
            assign year16[i]    = year_next[i];
        end
        else
        begin : g_zero
            assign ld_year16[i] = 1'b0;
            assign year16[i]    = 1'b0;
        end
    end

    assign ld_mod25 = mod25(ld_year16);
    assign ld_leap  = is_leap(ld_year16[3:0], ld_mod25);
    assign cur_leap = is_leap(year_reg[3:0], ymod_reg);
    assign cur_dim  = month_days(mon_reg, cur_leap);

    always_comb
    begin
        logic [MS_W:0]        ms_sum;
        logic [1:0]           sec_add;
        logic                 do_carry;
        logic [SEC_W:0]       sec_sum;
        logic                 min_c;
        logic                 hour_c;
        logic                 day_c;
        logic                 mon_c;
        logic                 year_c;
        logic [MONTH_W-1:0]   ld_mon;
        logic [DAY_W-1:0]     ld_dim;

        ms_next   = ms_reg;
        sec_next  = sec_reg;
        min_next  = min_reg;
        hour_next = hour_reg;
        day_next  = day_reg;
        mon_next  = mon_reg;
        year_next = year_reg;
        ymod_next = ymod_reg;

        ms_sum   = {1'b0, ms_reg} + {1'b0, tick_len};
        sec_add  = 2'd0;
        do_carry = 1'b0;
        min_c    = 1'b0;
        hour_c   = 1'b0;
        day_c    = 1'b0;
        mon_c    = 1'b0;
        year_c   = 1'b0;
        ld_mon   = item.load_month;
        ld_dim   = '0;

        case (item.func)
            FUNC_TICK:
            begin
                do_carry = 1'b1;
                // a tick of up to 1023 ms can pass two second marks
                if (ms_sum >= 11'd2000)
                begin
                    ms_next = MS_W'(ms_sum - 11'd2000);
                    sec_add = 2'd2;
                end
                else if (ms_sum >= 11'd1000)
                begin
                    ms_next = MS_W'(ms_sum - 11'd1000);
                    sec_add = 2'd1;
                end
                else
                begin
                    ms_next = ms_sum[MS_W-1:0];
                end
            end
            FUNC_ADD_SEC:
            begin
                do_carry = 1'b1;
                sec_add  = 2'd1;
            end
            FUNC_LOAD:
            begin
                ms_next   = (item.load_ms > MS_MAX) ? MS_MAX : item.load_ms;
                sec_next  = (item.load_second > SEC_MAX) ? SEC_MAX : item.load_second;
                min_next  = (item.load_minute > MIN_MAX) ? MIN_MAX : item.load_minute;
                hour_next = (item.load_hour > HOUR_MAX) ? HOUR_MAX : item.load_hour;
                if (item.load_month == '0)
                    ld_mon = MONTH_FIRST;
                else if (item.load_month > MONTH_MAX)
                    ld_mon = MONTH_MAX;
                ld_dim    = month_days(ld_mon, ld_leap);
                mon_next  = ld_mon;
                if (item.load_day == '0)
                    day_next = DAY_FIRST;
                else if (item.load_day > ld_dim)
                    day_next = ld_dim;
                else
                    day_next = item.load_day;
                year_next = ld_year;
                ymod_next = ld_mod25;
            end
            default:
            begin
            end
        endcase

        sec_sum = {1'b0, sec_reg} + (SEC_W + 1)'(sec_add);
        if (do_carry)
        begin
            if (sec_sum > (SEC_W + 1)'(SEC_MAX))
            begin
                sec_next = SEC_W'(sec_sum - (SEC_W + 1)'(SEC_MAX) - 7'd1);
                min_c    = 1'b1;
            end
            else
            begin
                sec_next = sec_sum[SEC_W-1:0];
            end
        end

        if (min_c)
        begin
            if (min_reg == MIN_MAX)
            begin
                min_next = '0;
                hour_c   = 1'b1;
            end
            else
            begin
                min_next = min_reg + 6'd1;
            end
        end

        if (hour_c)
        begin
            if (hour_reg == HOUR_MAX)
            begin
                hour_next = '0;
                day_c     = 1'b1;
            end
            else
            begin
                hour_next = hour_reg + 5'd1;
            end
        end

        if (day_c)
        begin
            if (day_reg >= cur_dim)
            begin
                day_next = DAY_FIRST;
                mon_c    = 1'b1;
            end
            else
            begin
                day_next = day_reg + 5'd1;
            end
        end

        if (mon_c)
        begin
            if (mon_reg >= MONTH_MAX)
            begin
                mon_next = MONTH_FIRST;
                year_c   = 1'b1;
            end
            else
            begin
                mon_next = mon_reg + 4'd1;
            end
        end

        if (year_c)
        begin
            year_next = year_reg + YEAR_BITS'(1);
            // wrapping to year zero restarts the residue
            if ((&year_reg) || (ymod_reg >= MOD25_MAX))
                ymod_next = '0;
            else
                ymod_next = ymod_reg + 5'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ms_reg   <= '0;
            sec_reg  <= '0;
            min_reg  <= '0;
            hour_reg <= '0;
            day_reg  <= DAY_FIRST;
            mon_reg  <= MONTH_FIRST;
            year_reg <= YEAR_BITS'(RESET_YEAR);
            ymod_reg <= MOD25_W'(RESET_YEAR_MOD25);
        end
        else if (fire)
        begin
            ms_reg   <= ms_next;
            sec_reg  <= sec_next;
            min_reg  <= min_next;
            hour_reg <= hour_next;
            day_reg  <= day_next;
            mon_reg  <= mon_next;
            year_reg <= year_next;
            ymod_reg <= ymod_next;
        end
    end

    assign now_next = '{ms:     ms_next,
                        second: sec_next,
                        minute: min_next,
                        hour:   hour_next,
                        day:    day_next,
                        month:  mon_next,
                        year:   year16};
endmodule

/* hw/rtl/ccc_out_stage.sv */
// result register: holds one time item until the stamp channel takes it
// depends on ccc_pkg and ccc_if
module ccc_out_stage (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           s1_valid,
    input  ccc_pkg::time_t now_next,
    output logic           advance,
    ccc_stamp_if.source    stamp
);
    import ccc_pkg::*;

    logic  valid_reg;
    logic  valid_next;
    time_t res_reg;

    assign advance = !valid_reg || stamp.ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (advance)
        begin
            valid_next = s1_valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && s1_valid)
        begin
            res_reg <= now_next;
        end
    end

    assign stamp.valid      = valid_reg;
    assign stamp.cur_ms     = res_reg.ms;
    assign stamp.cur_second = res_reg.second;
    assign stamp.cur_minute = res_reg.minute;
    assign stamp.cur_hour   = res_reg.hour;
    assign stamp.cur_day    = res_reg.day;
    assign stamp.cur_month  = res_reg.month;
    assign stamp.cur_year   = res_reg.year;
endmodule

/* hw/rtl/calendar_clock_counter.sv */
// from op accept to the stamp item: input register, then result register
// throughput: one item per cycle unless stamp stalls; ms-to-year carry is combinational
// an item can enter an empty input stage while a result waits; stages advance together
// reset: time 00:00:00.000 on 1 January 2000, tick length 10 ms, both stages empty
// depends on ccc_pkg, ccc_if, ccc_in_stage, ccc_time_core, ccc_out_stage
module calendar_clock_counter #(
    parameter int YEAR_BITS = ccc_pkg::YEAR_BITS_DEF
) (
    input  logic                     clk,
    input  logic                     rst_n,
    ccc_op_if.sink                   op,
    ccc_stamp_if.source              stamp,
    input  logic                     cfg_we,
    input  logic [ccc_pkg::MS_W-1:0] cfg_wdata
);
    import ccc_pkg::*;

    logic [MS_W-1:0] tick_len_reg;
    logic            advance;
    logic            s1_valid;
    item_t           s1_item;
    time_t           now_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tick_len_reg <= TICK_LEN_RESET;
        end
        else if (cfg_we)
        begin
            tick_len_reg <= cfg_wdata;
        end
    end

    ccc_in_stage u_in_stage (
        .clk      (clk),
        .rst_n    (rst_n),
        .op       (op),
        .advance  (advance),
        .s1_valid (s1_valid),
        .s1_item  (s1_item)
    );

    ccc_time_core #(
        .YEAR_BITS (YEAR_BITS)
    ) u_time_core (
        .clk      (clk),
        .rst_n    (rst_n),
        .fire     (s1_valid && advance),
        .item     (s1_item),
        .tick_len (tick_len_reg),
        .now_next (now_next)
    );

    ccc_out_stage u_out_stage (
        .clk      (clk),
        .rst_n    (rst_n),
        .s1_valid (s1_valid),
        .now_next (now_next),
        .advance  (advance),
        .stamp    (stamp)
    );

`ifndef ASSERT_OFF
    // an empty result register always leaves room for a new item
    a_ready_when_out_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !stamp.valid |-> op.ready)
        else $error("op not ready while result register empty");

    a_time_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        stamp.valid |-> (stamp.cur_ms <= MS_MAX) && (stamp.cur_second <= SEC_MAX)
                        && (stamp.cur_minute <= MIN_MAX) && (stamp.cur_hour <= HOUR_MAX))
        else $error("time of day out of range");

    a_date_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        stamp.valid |-> (stamp.cur_day != '0) && (stamp.cur_month != '0)
                        && (stamp.cur_month <= MONTH_MAX))
        else $error("date out of range");
`endif
endmodule
